[rtl/keyed_byte_permutation_builder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the keyed byte permutation builder
// Concurrent checks on the block's own logic; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYED_BYTE_PERMUTATION_BUILDER_ASSERT_SVH
`define KEYED_BYTE_PERMUTATION_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define KBPB_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("kbpb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define KBPB_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("kbpb: next-cycle check failed");

`else

`define KBPB_ASSERT_IMP(label, ck, rn, ante, cons)
`define KBPB_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

[rtl/kbpb_pkg.sv]
// ----------------------------------------------------------------------------
// kbpb_pkg
// Types, codes and constants shared by the permutation builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kbpb_pkg;

    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int KEY_BYTES   = 32;
    localparam int KEY_SEL_W   = $clog2(KEY_BYTES);
    localparam int ACC_W       = 32;
    localparam int DIV_CNT_W   = $clog2(ACC_W);
    localparam int CMD_W       = 2;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int REG_IDX_W   = 3;

    // Request command codes
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INV   = 2'd2;

    // Register indexes (byte address / 8)
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_ENABLE = 3'd4;

    // Shuffle generator
    localparam logic [ACC_W-1:0] LCG_SEED = 32'h9E37_79B9;
    localparam logic [ACC_W-1:0] LCG_MUL  = 32'd1664525;
    localparam logic [ACC_W-1:0] LCG_ADD  = 32'd1013904223;

    typedef logic [KEY_BYTES-1:0][BYTE_W-1:0] key_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] index;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [CMD_W-1:0]  kind;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAIN,
        ST_FILL,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_RD_K,
        ST_RD_J,
        ST_WR_K,
        ST_WR_J,
        ST_INV_RD,
        ST_INV_WR,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic issue;     // load a lookup request into the read stage
        logic finish;    // load the build result into the read stage
        logic fill;      // write identity at entry k of both tables
        logic acc_init;  // seed the accumulator
        logic mul;       // product = acc * multiplier
        logic add;       // acc = product + increment + key byte + k, start remainder
        logic div_step;  // one remainder bit
        logic rd_k;      // read forward[k]
        logic rd_j;      // read forward[j], hold forward[k]
        logic wr_k;      // forward[k] = forward[j]
        logic wr_j;      // forward[j] = old forward[k]
        logic inv_rd;    // read forward[k] for the inverse pass
        logic inv_wr;    // inverse[forward[k]] = k
        logic k_clr;
        logic k_inc;
        logic k_dec;
    } kbpb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic p_empty;   // read stage holds nothing
        logic p_free;    // read stage can take a request this cycle
        logic k_last;    // k is the last table entry
        logic k_one;     // k is one, last shuffle round
        logic div_last;  // final remainder step
    } kbpb_stat_t;

endpackage

`default_nettype wire

[rtl/kbpb_ram.sv]
// ----------------------------------------------------------------------------
// kbpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kbpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds when re is low
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/kbpb_datapath.sv]
// ----------------------------------------------------------------------------
// kbpb_datapath
// Forward and inverse tables, shuffle arithmetic and the lookup pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module kbpb_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kbpb_pkg::kbpb_cmd_t cmd,
    input  wire kbpb_pkg::req_t      req,
    input  wire kbpb_pkg::key_t      key,
    output      kbpb_pkg::kbpb_stat_t stat,
    output      logic                rsp_valid,
    input  wire logic                rsp_ready,
    output      kbpb_pkg::rsp_t      rsp
);

    import kbpb_pkg::*;

    // entry counter
    logic [TABLE_AW-1:0] k_reg, k_next;

    // shuffle arithmetic
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     prod_reg;
    logic [ACC_W-1:0]     quo_reg;
    logic [BYTE_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [BYTE_W-1:0]    tmp_reg;
    logic [TABLE_AW:0]    divisor;
    logic [TABLE_AW:0]    rem_shift;
    logic [BYTE_W-1:0]    rem_step;
    logic [BYTE_W-1:0]    key_byte;

    // table ports
    logic                fwd_we, fwd_re, inv_we, inv_re;
    logic [TABLE_AW-1:0] fwd_waddr, fwd_raddr, inv_waddr;
    logic [BYTE_W-1:0]   fwd_wdata, fwd_rdata, inv_rdata;

    // lookup pipeline
    logic             p_valid_reg;
    logic [CMD_W-1:0] p_kind_reg;
    logic             o_valid_reg;
    rsp_t             o_data_reg;
    logic             o_free, p_move;
    logic [BYTE_W-1:0] p_value;

    // ---------------- counter ----------------
    always_comb
    begin
        k_next = k_reg;
        if (cmd.k_clr)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + 1'b1;
        end
        else if (cmd.k_dec)
        begin
            k_next = k_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
            if (cmd.add)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // ---------------- generator and remainder ----------------
    assign key_byte  = key[k_reg[KEY_SEL_W-1:0]];
    assign acc_next  = prod_reg + LCG_ADD + ACC_W'(key_byte) + ACC_W'(k_reg);
    assign divisor   = {1'b0, k_reg} + 1'b1;
    assign rem_shift = {rem_reg, quo_reg[ACC_W-1]};
    // remainder stays below the divisor, so it always fits in a byte
    assign rem_step  = (rem_shift >= divisor) ? BYTE_W'(rem_shift - divisor)
                                              : rem_shift[BYTE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.acc_init)
        begin
            acc_reg <= LCG_SEED;
        end
        else if (cmd.add)
        begin
            acc_reg <= acc_next;
        end

        if (cmd.mul)
        begin
            prod_reg <= acc_reg * LCG_MUL;
        end

        if (cmd.add)
        begin
            quo_reg <= acc_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end

        if (cmd.rd_j)
        begin
            tmp_reg <= fwd_rdata;
        end
    end

    // ---------------- tables ----------------
    // rem_reg holds j from the end of the remainder until the next round
    assign fwd_we    = cmd.fill | cmd.wr_k | cmd.wr_j;
    assign fwd_waddr = cmd.wr_j ? rem_reg : k_reg;
    assign fwd_wdata = cmd.fill ? k_reg : (cmd.wr_k ? fwd_rdata : tmp_reg);
    assign fwd_re    = cmd.rd_k | cmd.rd_j | cmd.inv_rd
                     | (cmd.issue & (req.command == CMD_FWD));
    assign fwd_raddr = cmd.issue ? req.index : (cmd.rd_j ? rem_reg : k_reg);

    assign inv_we    = cmd.fill | cmd.inv_wr;
    assign inv_waddr = cmd.fill ? k_reg : fwd_rdata;
    assign inv_re    = cmd.issue & (req.command == CMD_INV);

    kbpb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .re    (fwd_re),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    kbpb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (k_reg),
        .re    (inv_re),
        .raddr (req.index),
        .rdata (inv_rdata)
    );

    // ---------------- lookup pipeline ----------------
    assign o_free = !o_valid_reg || rsp_ready;
    assign p_move = p_valid_reg && o_free;

    always_comb
    begin
        case (p_kind_reg)
            CMD_FWD: p_value = fwd_rdata;
            CMD_INV: p_value = inv_rdata;
            default: p_value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.issue || cmd.finish)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                p_valid_reg <= 1'b0;
            end

            if (p_move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            p_kind_reg <= req.command;
        end
        else if (cmd.finish)
        begin
            p_kind_reg <= CMD_BUILD;
        end

        if (p_move)
        begin
            o_data_reg.value <= p_value;
            o_data_reg.kind  <= p_kind_reg;
        end
    end

    assign rsp_valid = o_valid_reg;
    assign rsp       = o_data_reg;

    assign stat.p_empty  = !p_valid_reg;
    assign stat.p_free   = !p_valid_reg || o_free;
    assign stat.k_last   = (k_reg == TABLE_AW'(TABLE_DEPTH - 1));
    assign stat.k_one    = (k_reg == TABLE_AW'(1));
    assign stat.div_last = (cnt_reg == DIV_CNT_W'(ACC_W - 1));

endmodule

`default_nettype wire

[rtl/kbpb_ctrl.sv]
// ----------------------------------------------------------------------------
// kbpb_ctrl
// Sequencer for reset fill, table build and request acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module kbpb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire kbpb_pkg::req_t       req,
    input  wire logic                 key_enable,
    input  wire kbpb_pkg::kbpb_stat_t stat,
    output      logic                 req_ready,
    output      kbpb_pkg::kbpb_cmd_t  cmd
);

    import kbpb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill  = 1'b1;
                cmd.k_inc = 1'b1;
                if (stat.k_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = stat.p_free;
                if (req_valid && stat.p_free)
                begin
                    if (req.command == CMD_BUILD)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.issue = 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                // let a pending lookup leave before the tables are touched
                cmd.k_clr    = 1'b1;
                cmd.acc_init = 1'b1;
                if (stat.p_empty)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.k_last && key_enable)
                begin
                    // k stays at the last entry for the first round
                    state_next = ST_MUL;
                end
                else
                begin
                    cmd.k_inc = 1'b1;
                    if (stat.k_last)
                    begin
                        state_next = ST_INV_RD;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_RD_K;
                end
            end
            ST_RD_K:
            begin
                cmd.rd_k   = 1'b1;
                state_next = ST_RD_J;
            end
            ST_RD_J:
            begin
                cmd.rd_j   = 1'b1;
                state_next = ST_WR_K;
            end
            ST_WR_K:
            begin
                cmd.wr_k   = 1'b1;
                state_next = ST_WR_J;
            end
            ST_WR_J:
            begin
                cmd.wr_j = 1'b1;
                if (stat.k_one)
                begin
                    cmd.k_clr  = 1'b1;
                    state_next = ST_INV_RD;
                end
                else
                begin
                    cmd.k_dec  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_INV_RD:
            begin
                cmd.inv_rd = 1'b1;
                state_next = ST_INV_WR;
            end
            ST_INV_WR:
            begin
                cmd.inv_wr = 1'b1;
                cmd.k_inc  = 1'b1;
                state_next = stat.k_last ? ST_DONE : ST_INV_RD;
            end
            ST_DONE:
            begin
                // read stage is empty here: the build result enters at once
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/keyed_byte_permutation_builder.sv]
// ----------------------------------------------------------------------------
// keyed_byte_permutation_builder
// Keyed byte permutation and its inverse, built on command, read by lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready with a command and an index; each
//   request gives exactly one response on rsp_valid/rsp_ready, in order.
//   Forward and inverse lookups run one per cycle while the receiver keeps
//   rsp_ready high; each passes the table read port and one output register.
//   A build with the key enabled runs the identity fill, 255 rounds dominated
//   by the 32-step remainder loop and an inverse pass over all 256 entries,
//   and with the key disabled only the fill and the inverse pass; no other
//   request is accepted meanwhile, and its response carries value zero.
//   The key registers and key_enable are written over the APB port at byte
//   addresses 8*i; write them only while no request is outstanding.
//   After reset the block fills both tables with the identity with req_ready
//   low; register writes are taken throughout.
//   When the receiver holds rsp_ready low, the response stays in the output
//   register, one more lookup waits in the read stage, then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_byte_permutation_builder_assert.svh"

module keyed_byte_permutation_builder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kbpb_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [kbpb_pkg::CFG_DATA_W-1:0]   pwdata,
    output      logic [kbpb_pkg::CFG_DATA_W-1:0]   prdata,
    output      logic                              pready,
    input  wire logic                              req_valid,
    output      logic                              req_ready,
    input  wire kbpb_pkg::req_t                    req_data,
    output      logic                              rsp_valid,
    input  wire logic                              rsp_ready,
    output      kbpb_pkg::rsp_t                    rsp_data
);

    import kbpb_pkg::*;

    logic [CFG_DATA_W-1:0] key_word0_reg, key_word1_reg, key_word2_reg, key_word3_reg;
    logic                  key_enable_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_wr;
    key_t                  key;
    kbpb_cmd_t             ctrl_cmd;
    kbpb_stat_t            dp_stat;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word0_reg  <= '0;
            key_word1_reg  <= '0;
            key_word2_reg  <= '0;
            key_word3_reg  <= '0;
            key_enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_KEY_WORD0:  key_word0_reg  <= pwdata;
                REG_KEY_WORD1:  key_word1_reg  <= pwdata;
                REG_KEY_WORD2:  key_word2_reg  <= pwdata;
                REG_KEY_WORD3:  key_word3_reg  <= pwdata;
                REG_KEY_ENABLE: key_enable_reg <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY_WORD0:  prdata = key_word0_reg;
            REG_KEY_WORD1:  prdata = key_word1_reg;
            REG_KEY_WORD2:  prdata = key_word2_reg;
            REG_KEY_WORD3:  prdata = key_word3_reg;
            REG_KEY_ENABLE: prdata = CFG_DATA_W'(key_enable_reg);
            default:        prdata = '0;
        endcase
    end

    // key byte 0 sits in the low byte of key word 0
    assign key = {key_word3_reg, key_word2_reg, key_word1_reg, key_word0_reg};

    // ---------------- controller and datapath ----------------
    kbpb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req_data),
        .key_enable (key_enable_reg),
        .stat       (dp_stat),
        .req_ready  (req_ready),
        .cmd        (ctrl_cmd)
    );

    kbpb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .req       (req_data),
        .key       (key),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_data)
    );

    // ---------------- checks ----------------
    `KBPB_ASSERT_IMP(a_table_work_when_empty, clk, rst_n, ctrl_cmd.fill || ctrl_cmd.rd_k || ctrl_cmd.rd_j || ctrl_cmd.inv_rd, dp_stat.p_empty)
    `KBPB_ASSERT_NXT(a_lookup_enters_stage, clk, rst_n, req_valid && req_ready && req_data.command != CMD_BUILD, !dp_stat.p_empty)
    `KBPB_ASSERT_NXT(a_build_blocks_requests, clk, rst_n, req_valid && req_ready && req_data.command == CMD_BUILD, !req_ready)
    `KBPB_ASSERT_IMP(a_finish_has_room, clk, rst_n, ctrl_cmd.finish, dp_stat.p_free && !ctrl_cmd.issue)

endmodule

`default_nettype wire

[bench/permutation_checker.sv]
// ----------------------------------------------------------------------------
// permutation_checker
// Watches the configuration port and the request and response channels of the
// keyed byte permutation builder, keeps its own copy of the key and of both
// byte maps, predicts every response in order and compares it field by field.
// ----------------------------------------------------------------------------
module permutation_checker
    import kbpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  req_t                  req_data,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  rsp_t                  rsp_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam logic [31:0] SHUFFLE_SEED = 32'h9E37_79B9;
    localparam logic [31:0] MIX_MUL      = 32'd1664525;
    localparam logic [31:0] MIX_ADD      = 32'd1013904223;

    logic [CFG_DATA_W-1:0] key_word [4];
    logic                  key_on;
    logic [7:0]            fwd_map [256];
    logic [7:0]            inv_map [256];
    rsp_t                  awaited_rsp [$];
    rsp_t                  predicted;
    int                    n;

    // Rebuild both maps from the current key, as a build request does
    function automatic void shuffle_maps();
        logic [31:0] acc;
        logic [31:0] span;
        logic [4:0]  kb_sel;
        logic [7:0]  j;
        logic [7:0]  held;
        int          k;
        for (k = 0; k < 256; k++)
            fwd_map[k] = k[7:0];
        if (key_on)
        begin
            acc = SHUFFLE_SEED;
            for (k = 255; k > 0; k--)
            begin
                kb_sel = k[4:0];
                acc = acc * MIX_MUL + MIX_ADD
                    + 32'(key_word[kb_sel[4:3]][kb_sel[2:0]*8 +: 8]) + 32'(k);
                span = 32'(k) + 32'd1;
                j = 8'(acc % span);
                held = fwd_map[k];
                fwd_map[k] = fwd_map[j];
                fwd_map[j] = held;
            end
        end
        for (k = 0; k < 256; k++)
            inv_map[fwd_map[k]] = k[7:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (n = 0; n < 256; n++)
            begin
                fwd_map[n] = n[7:0];
                inv_map[n] = n[7:0];
            end
            for (n = 0; n < 4; n++)
                key_word[n] = '0;
            key_on = 1'b0;
            awaited_rsp.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:3])
                    REG_KEY_WORD0:  key_word[0] = pwdata;
                    REG_KEY_WORD1:  key_word[1] = pwdata;
                    REG_KEY_WORD2:  key_word[2] = pwdata;
                    REG_KEY_WORD3:  key_word[3] = pwdata;
                    REG_KEY_ENABLE: key_on = pwdata[0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                predicted.kind = req_data.command;
                case (req_data.command)
                    CMD_BUILD:
                    begin
                        shuffle_maps();
                        predicted.value = '0;
                    end
                    CMD_FWD: predicted.value = fwd_map[req_data.index];
                    CMD_INV: predicted.value = inv_map[req_data.index];
                    default: predicted.value = '0;
                endcase
                awaited_rsp.push_back(predicted);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, got value %h kind %0d",
                             $time, rsp_data.value, rsp_data.kind);
                    mismatches++;
                end
                else
                begin
                    predicted = awaited_rsp.pop_front();
                    if (rsp_data.value !== predicted.value)
                    begin
                        $display("%0t: value mismatch, expected %h, got %h",
                                 $time, predicted.value, rsp_data.value);
                        mismatches++;
                    end
                    if (rsp_data.kind !== predicted.kind)
                    begin
                        $display("%0t: kind mismatch, expected %0d, got %0d",
                                 $time, predicted.kind, rsp_data.kind);
                        mismatches++;
                    end
                end
            end
            outstanding <= awaited_rsp.size();
        end
    end

endmodule

[bench/keyed_byte_permutation_builder_tb.sv]
// ----------------------------------------------------------------------------
// keyed_byte_permutation_builder_tb
// Drives lookups, builds and the spare command into the permutation builder
// under several key settings, with random gaps on both channels, a long
// response hold-off and drained pauses; a separate checker predicts results.
// ----------------------------------------------------------------------------
module keyed_byte_permutation_builder_tb;
    import kbpb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 185;
    localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req_data;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp_data;

    int mismatches;
    int outstanding;
    int cycle_count;
    bit no_gaps;
    int rsp_hold_cycles;

    always #5 clk = ~clk;

    keyed_byte_permutation_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    permutation_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_key(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                             input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3,
                             input bit enable);
        apb_write(REG_KEY_WORD0, w0);
        apb_write(REG_KEY_WORD1, w1);
        apb_write(REG_KEY_WORD2, w2);
        apb_write(REG_KEY_WORD3, w3);
        apb_write(REG_KEY_ENABLE, {{(CFG_DATA_W-1){1'b0}}, enable});
    endtask

    // Leave valid high on return so the next request can follow back to back
    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] idx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(10, 0);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{command: cmd, index: idx};
        do @(posedge clk); while (!req_ready);
    endtask

    // Drop valid and hold until every predicted response has come back
    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Response side: random stall per response, plus a long hold on request
    initial
    begin
        int stall;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge clk);
                rsp_hold_cycles = 0;
            end
            stall = no_gaps ? 0 : $urandom_range(10, 0);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin
        int          phase;
        int          i;
        int          pick;
        logic [CMD_W-1:0] cmd;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        req_valid <= 1'b0;
        req_data  <= '0;
        no_gaps = 1'b0;
        rsp_hold_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Identity maps straight out of reset, then the spare command
        send_req(CMD_FWD, 8'h00);
        send_req(CMD_FWD, 8'hFF);
        send_req(CMD_INV, 8'h00);
        send_req(CMD_INV, 8'hFF);
        send_req(CMD_SPARE, 8'hAA);
        // Build with the key off and all key bytes zero
        send_req(CMD_BUILD, 8'h00);
        send_req(CMD_FWD, 8'h5A);
        drain();

        write_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
        send_req(CMD_BUILD, 8'hFF);
        send_req(CMD_FWD, 8'h00);
        send_req(CMD_FWD, 8'hFF);
        send_req(CMD_INV, 8'h00);
        send_req(CMD_INV, 8'hFF);
        send_req(CMD_SPARE, 8'hFF);
        drain();

        write_key('0, '0, '0, '0, 1'b1);
        send_req(CMD_BUILD, 8'h55);
        send_req(CMD_FWD, 8'h80);
        send_req(CMD_INV, 8'h01);
        drain();

        // Key off must ignore a nonzero key
        write_key(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
        send_req(CMD_BUILD, 8'h00);
        send_req(CMD_FWD, 8'hC3);
        send_req(CMD_INV, 8'h3C);
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_key('0, '0, '0, '0, 1'b1);
                1: write_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
                2: write_key(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
                default: write_key(rand_word(), rand_word(), rand_word(), rand_word(),
                                   $urandom_range(3, 0) != 0);
            endcase
            no_gaps = (phase % 3 == 2);
            send_req(CMD_BUILD, 8'($urandom_range(255, 0)));

            if (phase == 4)
            begin
                // Fill the pipeline against a stalled receiver
                no_gaps = 1'b1;
                rsp_hold_cycles = 300;
                for (i = 0; i < 24; i++)
                    send_req(CMD_FWD, 8'($urandom_range(255, 0)));
                no_gaps = 1'b0;
            end

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 5 && i == PHASE_ITEMS / 2)
                    drain();
                pick = $urandom_range(99, 0);
                if ($urandom_range(63, 0) == 0)
                    cmd = CMD_BUILD;
                else if (pick < 5)
                    cmd = CMD_SPARE;
                else if (pick < 52)
                    cmd = CMD_FWD;
                else
                    cmd = CMD_INV;
                send_req(cmd, 8'($urandom_range(255, 0)));
            end
            drain();
        end

        no_gaps = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
